// ===== rtl/core/indexed_min_heap_defines.svh =====
// assertion macros for the checker file
`ifndef INDEXED_MIN_HEAP_DEFINES_SVH
`define INDEXED_MIN_HEAP_DEFINES_SVH

// condition implies consequence in the same cycle
`define IMH_ASSERT_IMPL(lbl, clk, rstn, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (cons)) \
        else $error("indexed_min_heap assertion failed");

// condition implies consequence in the next cycle
`define IMH_ASSERT_NEXT(lbl, clk, rstn, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (cons)) \
        else $error("indexed_min_heap assertion failed");

`endif

// ===== rtl/core/imh_pkg.sv =====
package imh_pkg;

    localparam int VTX_W = 10;
    localparam int KEY_W = 32;
    localparam int ENT_W = 11;

    // operation codes
    localparam logic [1:0] OP_APPEND   = 2'd0;
    localparam logic [1:0] OP_EXTRACT  = 2'd1;
    localparam logic [1:0] OP_DECREASE = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_NOTIN = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [VTX_W-1:0] vertex;
        logic [KEY_W-1:0] key;
    } in_beat_t;

    typedef struct packed {
        logic [VTX_W-1:0] out_vertex;
        logic [KEY_W-1:0] out_key;
        logic [1:0]       status;
        logic             member;
        logic [ENT_W-1:0] entries;
    } out_beat_t;

    // classified command handed from front to back
    typedef struct packed {
        in_beat_t beat;
        logic     vtx_ok;
    } cmd_t;

    // one heap slot
    typedef struct packed {
        logic [VTX_W-1:0] vertex;
        logic [KEY_W-1:0] key;
    } entry_t;

endpackage

// ===== rtl/core/imh_ram.sv =====
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/imh_front.sv =====
module imh_front #(
    parameter int VERTICES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  imh_pkg::in_beat_t s_data,
    output logic              cmd_valid,
    input  logic              cmd_pop,
    output imh_pkg::cmd_t     cmd
);

    import imh_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       cls;

    // classify incoming beat
    always_comb begin
        cls.beat   = s_data;
        cls.vtx_ok = (32'(s_data.vertex) < VERTICES);
    end

    assign s_ready   = (cnt_reg != 2'd2);
    assign push      = s_valid && s_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/core/imh_back.sv =====
module imh_back #(
    parameter int VERTICES = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cmd_valid,
    output logic                            cmd_pop,
    input  imh_pkg::cmd_t                   cmd,
    output logic                            m_valid,
    input  logic                            m_ready,
    output imh_pkg::out_beat_t              m_data,
    output logic                            heap_we,
    output logic [$clog2(VERTICES)-1:0]     heap_waddr,
    output imh_pkg::entry_t                 heap_wdata,
    output logic [$clog2(VERTICES)-1:0]     heap_raddr,
    input  imh_pkg::entry_t                 heap_rdata,
    output logic                            pos_we,
    output logic [$clog2(VERTICES)-1:0]     pos_waddr,
    output logic [$clog2(VERTICES)-1:0]     pos_wdata,
    output logic [$clog2(VERTICES)-1:0]     pos_raddr,
    input  logic [$clog2(VERTICES)-1:0]     pos_rdata
);

    import imh_pkg::*;

    localparam int PW = $clog2(VERTICES);
    localparam int CW = $clog2(VERTICES + 1);

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_LOOKUP = 13'b0000000000010,
        ST_MEMB   = 13'b0000000000100,
        ST_XROOT  = 13'b0000000001000,
        ST_XLAST  = 13'b0000000010000,
        ST_XPOS   = 13'b0000000100000,
        ST_SDISS  = 13'b0000001000000,
        ST_SDL    = 13'b0000010000000,
        ST_SDR    = 13'b0000100000000,
        ST_SDMV   = 13'b0001000000000,
        ST_SUISS  = 13'b0010000000000,
        ST_SUCMP  = 13'b0100000000000,
        ST_FIN    = 13'b1000000000000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [PW-1:0]     idx_reg, idx_next;
    entry_t            cur_reg, cur_next;
    entry_t            root_reg, root_next;
    entry_t            cand_reg, cand_next;
    logic [PW-1:0]     cand_idx_reg, cand_idx_next;
    logic              cand_lt_reg, cand_lt_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_reg, out_next;

    logic              fin;
    logic [1:0]        fin_status;
    logic              fin_member;
    logic              fin_root;
    logic [PW+1:0]     l_w, r_w, cnt_w;
    logic [PW-1:0]     par;
    logic              memb;
    logic [KEY_W-1:0]  best_key;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // child, parent and membership helpers
    always_comb begin
        l_w      = (PW+2)'({idx_reg, 1'b1});
        r_w      = l_w + (PW+2)'(1);
        cnt_w    = (PW+2)'(cnt_reg);
        par      = (idx_reg - PW'(1)) >> 1;
        memb     = ((PW+1)'(idx_reg) < (PW+1)'(cnt_reg))
                   && (heap_rdata.vertex == cmd_reg.beat.vertex);
        best_key = cand_lt_reg ? cand_reg.key : cur_reg.key;
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        root_next      = root_reg;
        cand_next      = cand_reg;
        cand_idx_next  = cand_idx_reg;
        cand_lt_next   = cand_lt_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        cmd_pop        = 1'b0;
        fin            = 1'b0;
        fin_status     = STAT_OK;
        fin_member     = 1'b0;
        fin_root       = 1'b0;
        heap_we        = 1'b0;
        heap_waddr     = '0;
        heap_wdata     = '0;
        heap_raddr     = '0;
        pos_we         = 1'b0;
        pos_waddr      = '0;
        pos_wdata      = '0;
        pos_raddr      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && (!out_valid_reg || m_ready)) begin
                    cmd_pop  = 1'b1;
                    cmd_next = cmd;
                    pos_raddr = PW'(cmd.beat.vertex);
                    unique case (cmd.beat.op)
                        OP_APPEND: begin
                            if (!cmd.vtx_ok) begin
                                fin        = 1'b1;
                                fin_status = STAT_NOTIN;
                            end else if (cnt_reg >= CW'(VERTICES)) begin
                                fin        = 1'b1;
                                fin_status = STAT_FULL;
                            end else begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        OP_EXTRACT: begin
                            if (cnt_reg == '0) begin
                                fin        = 1'b1;
                                fin_status = STAT_EMPTY;
                            end else begin
                                heap_raddr = '0;
                                state_next = ST_XROOT;
                            end
                        end
                        OP_DECREASE: begin
                            if (!cmd.vtx_ok) begin
                                fin        = 1'b1;
                                fin_status = STAT_NOTIN;
                            end else begin
                                state_next = ST_LOOKUP;
                            end
                        end
                        default: begin
                            if (!cmd.vtx_ok) begin
                                fin = 1'b1;
                            end else begin
                                state_next = ST_LOOKUP;
                            end
                        end
                    endcase
                end
            end
            // slot of vertex is back, fetch that slot
            ST_LOOKUP: begin
                idx_next   = pos_rdata;
                heap_raddr = pos_rdata;
                state_next = ST_MEMB;
            end
            ST_MEMB: begin
                state_next = ST_IDLE;
                case (cmd_reg.beat.op)
                    OP_APPEND: begin
                        fin = 1'b1;
                        if (!memb) begin
                            heap_we    = 1'b1;
                            heap_waddr = PW'(cnt_reg);
                            heap_wdata = '{vertex: cmd_reg.beat.vertex,
                                           key: cmd_reg.beat.key};
                            pos_we     = 1'b1;
                            pos_waddr  = PW'(cmd_reg.beat.vertex);
                            pos_wdata  = PW'(cnt_reg);
                            cnt_next   = cnt_reg + CW'(1);
                        end
                    end
                    OP_DECREASE: begin
                        if (!memb) begin
                            fin        = 1'b1;
                            fin_status = STAT_NOTIN;
                        end else begin
                            cur_next   = '{vertex: cmd_reg.beat.vertex,
                                           key: cmd_reg.beat.key};
                            state_next = ST_SUISS;
                        end
                    end
                    default: begin
                        fin        = 1'b1;
                        fin_member = memb;
                    end
                endcase
            end
            // extract: root is back, fetch last entry
            ST_XROOT: begin
                root_next  = heap_rdata;
                heap_raddr = PW'(cnt_reg - CW'(1));
                state_next = ST_XLAST;
            end
            ST_XLAST: begin
                cur_next   = heap_rdata;
                heap_we    = 1'b1;
                heap_waddr = '0;
                heap_wdata = heap_rdata;
                pos_we     = 1'b1;
                pos_waddr  = PW'(root_reg.vertex);
                pos_wdata  = PW'(cnt_reg - CW'(1));
                cnt_next   = cnt_reg - CW'(1);
                idx_next   = '0;
                state_next = ST_XPOS;
            end
            ST_XPOS: begin
                pos_we     = 1'b1;
                pos_waddr  = PW'(cur_reg.vertex);
                pos_wdata  = '0;
                state_next = ST_SDISS;
            end
            // sift down: fetch left child
            ST_SDISS: begin
                if (l_w < cnt_w) begin
                    heap_raddr = PW'(l_w);
                    state_next = ST_SDL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SDL: begin
                cand_next     = heap_rdata;
                cand_idx_next = PW'(l_w);
                cand_lt_next  = heap_rdata.key < cur_reg.key;
                if (r_w < cnt_w) begin
                    heap_raddr = PW'(r_w);
                    state_next = ST_SDR;
                end else begin
                    state_next = ST_SDMV;
                end
            end
            ST_SDR: begin
                if (heap_rdata.key < best_key) begin
                    cand_next     = heap_rdata;
                    cand_idx_next = PW'(r_w);
                    cand_lt_next  = 1'b1;
                end
                state_next = ST_SDMV;
            end
            ST_SDMV: begin
                if (cand_lt_reg) begin
                    heap_we    = 1'b1;
                    heap_waddr = idx_reg;
                    heap_wdata = cand_reg;
                    pos_we     = 1'b1;
                    pos_waddr  = PW'(cand_reg.vertex);
                    pos_wdata  = idx_reg;
                    idx_next   = cand_idx_reg;
                    state_next = ST_SDISS;
                end else begin
                    state_next = ST_FIN;
                end
            end
            // sift up: fetch parent
            ST_SUISS: begin
                if (idx_reg != '0) begin
                    heap_raddr = par;
                    state_next = ST_SUCMP;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SUCMP: begin
                if (cur_reg.key < heap_rdata.key) begin
                    heap_we    = 1'b1;
                    heap_waddr = idx_reg;
                    heap_wdata = heap_rdata;
                    pos_we     = 1'b1;
                    pos_waddr  = PW'(heap_rdata.vertex);
                    pos_wdata  = idx_reg;
                    idx_next   = par;
                    state_next = ST_SUISS;
                end else begin
                    state_next = ST_FIN;
                end
            end
            // place the moving entry in its final slot
            ST_FIN: begin
                heap_we    = 1'b1;
                heap_waddr = idx_reg;
                heap_wdata = cur_reg;
                pos_we     = 1'b1;
                pos_waddr  = PW'(cur_reg.vertex);
                pos_wdata  = idx_reg;
                fin        = 1'b1;
                fin_root   = (cmd_reg.beat.op == OP_EXTRACT);
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // result beat
        if (fin) begin
            out_valid_next      = 1'b1;
            out_next.out_vertex = fin_root ? root_reg.vertex : '0;
            out_next.out_key    = fin_root ? root_reg.key : '0;
            out_next.status     = fin_status;
            out_next.member     = fin_member;
            out_next.entries    = ENT_W'(cnt_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        cur_reg      <= cur_next;
        root_reg     <= root_next;
        cand_reg     <= cand_next;
        cand_idx_reg <= cand_idx_next;
        cand_lt_reg  <= cand_lt_next;
        out_reg      <= out_next;
    end

endmodule

// ===== rtl/core/indexed_min_heap.sv =====
// indexed binary min-heap with vertex-to-slot table, one result beat per input beat
// append and query look up the vertex slot, then test membership; out-of-range, empty and
// full checks answer from idle; extract reads root and last entry, then sifts down with two
// child reads on the heap ram port per level; decrease key sifts up by reading each parent;
// one operation in the back end at a time; a 2-deep command queue takes beats while it works
// synchronous active-low reset empties the heap and the queue; ram contents are not cleared
module indexed_min_heap #(
    parameter int VERTICES = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  imh_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output imh_pkg::out_beat_t m_data
);

    import imh_pkg::*;

    localparam int PW = $clog2(VERTICES);

    logic          cmd_valid;
    logic          cmd_pop;
    cmd_t          cmd;
    logic          heap_we;
    logic [PW-1:0] heap_waddr;
    entry_t        heap_wdata;
    logic [PW-1:0] heap_raddr;
    entry_t        heap_rdata;
    logic          pos_we;
    logic [PW-1:0] pos_waddr;
    logic [PW-1:0] pos_wdata;
    logic [PW-1:0] pos_raddr;
    logic [PW-1:0] pos_rdata;

    // front: accept and classify
    imh_front #(.VERTICES(VERTICES)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // back: heap sequencer
    imh_back #(.VERTICES(VERTICES)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd_valid  (cmd_valid),
        .cmd_pop    (cmd_pop),
        .cmd        (cmd),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .heap_we    (heap_we),
        .heap_waddr (heap_waddr),
        .heap_wdata (heap_wdata),
        .heap_raddr (heap_raddr),
        .heap_rdata (heap_rdata),
        .pos_we     (pos_we),
        .pos_waddr  (pos_waddr),
        .pos_wdata  (pos_wdata),
        .pos_raddr  (pos_raddr),
        .pos_rdata  (pos_rdata)
    );

    // heap slots
    imh_ram #(.WIDTH($bits(entry_t)), .DEPTH(VERTICES)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    // slot of each vertex
    imh_ram #(.WIDTH(PW), .DEPTH(VERTICES)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

endmodule

// ===== rtl/core/imh_checker.sv =====
`include "indexed_min_heap_defines.svh"

module imh_checker #(
    parameter int VERTICES = 1024
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input imh_pkg::in_beat_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input imh_pkg::out_beat_t m_data
);

    import imh_pkg::*;

    // stalled result beat holds
    `IMH_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // empty status only with an empty heap
    `IMH_ASSERT_IMPL(a_empty_cnt, aclk, aresetn, m_valid && (m_data.status == STAT_EMPTY), m_data.entries == '0)

    // full status only with a full heap
    `IMH_ASSERT_IMPL(a_full_cnt, aclk, aresetn, m_valid && (m_data.status == STAT_FULL), m_data.entries == ENT_W'(VERTICES))

    // member flag only on a good status with a non-empty heap
    `IMH_ASSERT_IMPL(a_member_ok, aclk, aresetn, m_valid && m_data.member, (m_data.status == STAT_OK) && (m_data.entries != '0))

endmodule

bind indexed_min_heap imh_checker #(.VERTICES(VERTICES)) u_imh_checker (.*);
